>>> sv/sliding_window_arq_sender_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ARQ sender checkers
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_ARQ_SENDER_ASSERT_SVH
`define SLIDING_WINDOW_ARQ_SENDER_ASSERT_SVH

// same-cycle implication
`define SWARQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWARQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/swarq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swarq_pkg
// Shared types, codes and defaults of the selective-repeat ARQ sender.
// ----------------------------------------------------------------------------
package swarq_pkg;

    localparam int DEF_MAX_PACKETS = 256;
    localparam int DEF_WINDOW_SIZE = 8;
    localparam int DEF_GROUP_SIZE  = 4;

    typedef enum logic [2:0] {
        CMD_START  = 3'd0,
        CMD_ACK    = 3'd1,
        CMD_TICK   = 3'd2,
        CMD_TXDONE = 3'd3,
        CMD_ABORT  = 3'd4
    } t_command;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_PARITY = 2'd1;
    localparam logic [1:0] KIND_MARKER = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    localparam logic [1:0] CFG_RETX_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_MIN_GAP      = 2'd1;
    localparam logic [1:0] CFG_START_GUARD  = 2'd2;

    localparam logic [15:0] RST_RETX_TIMEOUT = 16'd2000;
    localparam logic [15:0] RST_MIN_GAP      = 16'd20;
    localparam logic [15:0] RST_START_GUARD  = 16'd100;

    localparam logic [1:0] MARKER_REPEATS = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic latch;
        logic start;
        logic txdone;
        logic abort;
        logic ack_mark;
        logic adv;
        logic emit_done;
        logic emit_marker;
        logic emit_data;
        logic emit_parity;
        logic scan_init;
        logic scan_next;
        logic gscan_init;
        logic gscan_next;
        logic to_clear;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic id_match;
        logic gap_ok;
        logic marker_pend;
        logic run_ok;
        logic scan_in;
        logic cand;
        logic busy;
        logic grp_end;
        logic grp_hit;
        logic adv_ok;
        logic all_done;
        logic complete;
        logic to_hit;
        logic out_full;
    } t_status;

endpackage

>>> sv/swarq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swarq_ctrl
// Sequencer: decodes requests and steps the window, group and timeout scans.
// ----------------------------------------------------------------------------
module swarq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [2:0]         i_command,
    output logic               o_in_ready,
    input  swarq_pkg::t_status i_status,
    output swarq_pkg::t_cmd    o_cmd
);
    import swarq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_START, ST_ACK, ST_ADV, ST_TXDONE, ST_ABORT,
        ST_MARK, ST_DSCAN, ST_PAR, ST_TORD, ST_TOCMP
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.latch = 1'b1;
                    case (t_command'(i_command))
                        CMD_START:  n_state = ST_START;
                        CMD_ACK:    n_state = ST_ACK;
                        CMD_TICK:   n_state = ST_MARK;
                        CMD_TXDONE: n_state = ST_TXDONE;
                        CMD_ABORT:  n_state = ST_ABORT;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_START: begin
                cmd.start = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_TXDONE: begin
                cmd.txdone = 1'b1;
                n_state    = ST_IDLE;
            end
            ST_ABORT: begin
                cmd.abort = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_ACK: begin
                if (i_status.id_match) begin
                    cmd.ack_mark = 1'b1;
                    n_state      = ST_ADV;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_ADV: begin
                priority if (i_status.adv_ok) begin
                    cmd.adv = 1'b1;
                end else if (i_status.all_done && !i_status.complete) begin
                    // hold until the output register frees up
                    if (!i_status.out_full) begin
                        cmd.emit_done = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MARK: begin
                if (!(i_status.marker_pend && i_status.gap_ok && i_status.out_full)) begin
                    cmd.emit_marker = i_status.marker_pend && i_status.gap_ok;
                    if (i_status.run_ok) begin
                        cmd.scan_init = 1'b1;
                        n_state       = ST_DSCAN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_DSCAN: begin
                priority if (!i_status.scan_in) begin
                    cmd.gscan_init = 1'b1;
                    n_state        = ST_PAR;
                end else if (i_status.cand) begin
                    if (!(i_status.gap_ok && i_status.out_full)) begin
                        cmd.emit_data  = i_status.gap_ok;
                        cmd.gscan_init = 1'b1;
                        n_state        = ST_PAR;
                    end
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            ST_PAR: begin
                priority if (i_status.busy || !i_status.grp_end) begin
                    cmd.scan_init = 1'b1;
                    n_state       = ST_TORD;
                end else if (i_status.grp_hit) begin
                    if (!(i_status.gap_ok && i_status.out_full)) begin
                        cmd.emit_parity = i_status.gap_ok;
                        cmd.scan_init   = 1'b1;
                        n_state         = ST_TORD;
                    end
                end else begin
                    cmd.gscan_next = 1'b1;
                end
            end
            ST_TORD: begin
                // send time read is issued here, compared next cycle
                n_state = i_status.scan_in ? ST_TOCMP : ST_IDLE;
            end
            ST_TOCMP: begin
                cmd.to_clear  = i_status.to_hit;
                cmd.scan_next = 1'b1;
                n_state       = ST_TORD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cmd      = cmd;

endmodule

>>> sv/swarq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swarq_dp
// Datapath: transfer state, packet flags, send time memory, output register.
// ----------------------------------------------------------------------------
module swarq_dp #(
    parameter int MAX_PACKETS = swarq_pkg::DEF_MAX_PACKETS,
    parameter int WINDOW_SIZE = swarq_pkg::DEF_WINDOW_SIZE,
    parameter int GROUP_SIZE  = swarq_pkg::DEF_GROUP_SIZE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic [31:0]        i_now_ms,
    input  logic [8:0]         i_requested_packets,
    input  logic [15:0]        i_ack_transfer,
    input  logic [2:0]         i_ack_word_index,
    input  logic [31:0]        i_ack_bits,
    input  logic [8:0]         i_ack_limit,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_packet_number,
    output logic [15:0]        o_current_transfer,
    output logic [8:0]         o_advertised_count,
    input  swarq_pkg::t_cmd    i_cmd,
    output swarq_pkg::t_status o_status
);
    import swarq_pkg::*;

    localparam int CW  = $clog2(MAX_PACKETS + 1);
    localparam int IW  = $clog2(MAX_PACKETS);
    localparam int EW  = $clog2(MAX_PACKETS + WINDOW_SIZE + 1);
    localparam int SW  = $clog2(GROUP_SIZE);
    localparam int NG  = MAX_PACKETS / GROUP_SIZE;
    localparam int GW  = (NG + 1 > 1) ? $clog2(NG + 1) : 1;
    localparam int NGE = 1 << GW;

    logic [15:0] r_cfg_retx, r_cfg_gap, r_cfg_guard;

    logic [31:0] r_now;
    logic [8:0]  r_req;
    logic [15:0] r_ack_id;
    logic [2:0]  r_ack_w;
    logic [31:0] r_ack_bits;
    logic [8:0]  r_ack_lim;

    logic [MAX_PACKETS-1:0] r_acked, r_sent;
    logic [NGE-1:0]         r_grp_pend;
    logic [31:0]            r_send_time [MAX_PACKETS];
    logic [31:0]            r_rd_time;

    logic [CW-1:0] r_base, r_total, r_idx;
    logic [SW-1:0] r_base_sub, r_sub;
    logic [GW-1:0] r_base_grp, r_grp, r_g;
    logic [15:0]   r_xfer;
    logic          r_busy, r_active, r_complete;
    logic [31:0]   r_last_end, r_ready_time;
    logic [1:0]    r_markers;

    logic          r_out_valid;
    logic [1:0]    r_kind;
    logic [7:0]    r_num;
    logic [15:0]   r_out_xfer;
    logic [8:0]    r_cnt;

    logic [MAX_PACKETS-1:0] ack_hit;
    logic [CW-1:0]          req_sat;
    logic [15:0]            n_xfer;
    logic [31:0]            since_gap, since_ready, since_sent;
    logic                   gap_ok, scan_in, grp_last, any_emit;
    logic [IW-1:0]          idx_a, base_a;

    for (genvar p = 0; p < MAX_PACKETS; p++) begin : g_hit
        localparam int PW = p / 32;
        assign ack_hit[p] = (PW < 8) && (r_ack_w == 3'(PW)) && r_ack_bits[p % 32]
                            && (int'(r_ack_lim) > p);
    end

    assign req_sat   = (int'(r_req) > MAX_PACKETS) ? CW'(MAX_PACKETS) : CW'(r_req);
    assign n_xfer    = (r_xfer == 16'hFFFF) ? 16'd1 : r_xfer + 16'd1;
    assign since_gap   = r_now - r_last_end;
    assign since_ready = r_now - r_ready_time;
    assign since_sent  = r_now - r_rd_time;
    assign gap_ok    = !r_busy && (since_gap >= {16'd0, r_cfg_gap});
    assign idx_a     = r_idx[IW-1:0];
    assign base_a    = r_base[IW-1:0];
    assign scan_in   = (r_idx < r_total) &&
                       (EW'(r_idx) < EW'(r_base) + EW'(WINDOW_SIZE));
    assign grp_last  = (r_sub == SW'(GROUP_SIZE - 1)) ||
                       ((CW + 1)'(r_idx) + (CW + 1)'(1) == (CW + 1)'(r_total));
    assign any_emit  = i_cmd.emit_done | i_cmd.emit_marker | i_cmd.emit_data
                       | i_cmd.emit_parity;

    always_comb begin
        o_status             = '0;
        o_status.id_match    = (r_ack_id == r_xfer);
        o_status.gap_ok      = gap_ok;
        o_status.marker_pend = (r_markers != 2'd0);
        o_status.run_ok      = r_active && !r_complete && !since_ready[31];
        o_status.scan_in     = scan_in;
        o_status.cand        = !r_acked[idx_a] && !r_sent[idx_a];
        o_status.busy        = r_busy;
        o_status.grp_end     = (int'(r_g) < NG);
        o_status.grp_hit     = r_grp_pend[r_g];
        o_status.adv_ok      = (r_base < r_total) && r_acked[base_a];
        o_status.all_done    = (r_base >= r_total);
        o_status.complete    = r_complete;
        o_status.to_hit      = r_sent[idx_a] && !r_acked[idx_a] &&
                               (since_sent > {16'd0, r_cfg_retx});
        o_status.out_full    = r_out_valid && !i_out_ready;
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_retx  <= RST_RETX_TIMEOUT;
            r_cfg_gap   <= RST_MIN_GAP;
            r_cfg_guard <= RST_START_GUARD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RETX_TIMEOUT: r_cfg_retx  <= i_cfg_data;
                CFG_MIN_GAP:      r_cfg_gap   <= i_cfg_data;
                CFG_START_GUARD:  r_cfg_guard <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request fields, send time memory, scan pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_now      <= i_now_ms;
            r_req      <= i_requested_packets;
            r_ack_id   <= i_ack_transfer;
            r_ack_w    <= i_ack_word_index;
            r_ack_bits <= i_ack_bits;
            r_ack_lim  <= i_ack_limit;
        end
        if (i_cmd.emit_data) begin
            r_send_time[idx_a] <= r_now;
        end
        r_rd_time <= r_send_time[idx_a];
        if (i_cmd.scan_init) begin
            r_idx <= r_base;
            r_sub <= r_base_sub;
            r_grp <= r_base_grp;
        end else if (i_cmd.scan_next) begin
            r_idx <= r_idx + CW'(1);
            if (r_sub == SW'(GROUP_SIZE - 1)) begin
                r_sub <= '0;
                r_grp <= r_grp + GW'(1);
            end else begin
                r_sub <= r_sub + SW'(1);
            end
        end
        if (i_cmd.gscan_init) begin
            r_g <= '0;
        end else if (i_cmd.gscan_next) begin
            r_g <= r_g + GW'(1);
        end
    end

    // transfer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acked      <= '0;
            r_sent       <= '0;
            r_grp_pend   <= '0;
            r_base       <= '0;
            r_base_sub   <= '0;
            r_base_grp   <= '0;
            r_total      <= '0;
            r_xfer       <= '0;
            r_busy       <= 1'b0;
            r_last_end   <= '0;
            r_ready_time <= '0;
            r_active     <= 1'b0;
            r_complete   <= 1'b0;
            r_markers    <= '0;
        end else begin
            if (i_cmd.start) begin
                r_active <= 1'b0;
                r_xfer   <= n_xfer;
                if (req_sat == '0) begin
                    r_total    <= '0;
                    r_markers  <= MARKER_REPEATS;
                    r_complete <= 1'b1;
                end else begin
                    r_complete   <= 1'b0;
                    r_total      <= req_sat;
                    r_acked      <= '0;
                    r_sent       <= '0;
                    r_grp_pend   <= '0;
                    r_base       <= '0;
                    r_base_sub   <= '0;
                    r_base_grp   <= '0;
                    r_active     <= 1'b1;
                    r_ready_time <= r_now + {16'd0, r_cfg_guard};
                end
            end
            if (i_cmd.txdone) begin
                r_busy     <= 1'b0;
                r_last_end <= r_now;
            end
            if (i_cmd.abort) begin
                r_active <= 1'b0;
            end
            if (i_cmd.ack_mark) begin
                r_acked <= r_acked | ack_hit;
            end
            if (i_cmd.adv) begin
                r_base <= r_base + CW'(1);
                if (r_base_sub == SW'(GROUP_SIZE - 1)) begin
                    r_base_sub <= '0;
                    r_base_grp <= r_base_grp + GW'(1);
                end else begin
                    r_base_sub <= r_base_sub + SW'(1);
                end
            end
            if (i_cmd.emit_done) begin
                r_complete <= 1'b1;
            end
            if (i_cmd.emit_marker) begin
                r_busy    <= 1'b1;
                r_markers <= r_markers - 2'd1;
            end
            if (i_cmd.emit_data) begin
                r_busy        <= 1'b1;
                r_sent[idx_a] <= 1'b1;
                if (grp_last) begin
                    r_grp_pend[r_grp] <= 1'b1;
                end
            end
            if (i_cmd.emit_parity) begin
                r_busy          <= 1'b1;
                r_grp_pend[r_g] <= 1'b0;
            end
            if (i_cmd.to_clear) begin
                // expire: make resendable, drop its parity notice
                r_sent[idx_a]     <= 1'b0;
                r_grp_pend[r_grp] <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (any_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (any_emit) begin
            r_out_xfer <= r_xfer;
            priority if (i_cmd.emit_marker) begin
                r_kind <= KIND_MARKER;
                r_num  <= 8'd0;
                r_cnt  <= 9'd0;
            end else if (i_cmd.emit_data) begin
                r_kind <= KIND_DATA;
                r_num  <= 8'(r_idx);
                r_cnt  <= 9'(r_total);
            end else if (i_cmd.emit_parity) begin
                r_kind <= KIND_PARITY;
                r_num  <= 8'(r_g);
                r_cnt  <= 9'(r_total);
            end else begin
                r_kind <= KIND_DONE;
                r_num  <= 8'd0;
                r_cnt  <= 9'(r_total);
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_kind             = r_kind;
    assign o_packet_number    = r_num;
    assign o_current_transfer = r_out_xfer;
    assign o_advertised_count = r_cnt;

endmodule

>>> sv/sliding_window_arq_sender.sv
`timescale 1ns / 1ps
// A matching ack advances the window base over each acknowledged packet in turn. A tick
// may send a marker; on a live transfer it runs a window scan, a parity group scan over
// MAX_PACKETS/GROUP_SIZE groups and a timeout pass with one registered send time read
// per packet. One request at a time; a result waits in the output register. Reset is
// synchronous, active low, and clears all flags; the send time memory is not cleared.
// ----------------------------------------------------------------------------
// sliding_window_arq_sender
// Transmit side of a selective-repeat transfer with parity group notices.
// ----------------------------------------------------------------------------
module sliding_window_arq_sender #(
    parameter int MAX_PACKETS = swarq_pkg::DEF_MAX_PACKETS,
    parameter int WINDOW_SIZE = swarq_pkg::DEF_WINDOW_SIZE,
    parameter int GROUP_SIZE  = swarq_pkg::DEF_GROUP_SIZE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_now_ms,
    input  logic [8:0]  i_requested_packets,
    input  logic [15:0] i_ack_transfer,
    input  logic [2:0]  i_ack_word_index,
    input  logic [31:0] i_ack_bits,
    input  logic [8:0]  i_ack_limit,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_packet_number,
    output logic [15:0] o_current_transfer,
    output logic [8:0]  o_advertised_count
);
    import swarq_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    swarq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    swarq_dp #(
        .MAX_PACKETS (MAX_PACKETS),
        .WINDOW_SIZE (WINDOW_SIZE),
        .GROUP_SIZE  (GROUP_SIZE)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_now_ms            (i_now_ms),
        .i_requested_packets (i_requested_packets),
        .i_ack_transfer      (i_ack_transfer),
        .i_ack_word_index    (i_ack_word_index),
        .i_ack_bits          (i_ack_bits),
        .i_ack_limit         (i_ack_limit),
        .i_out_ready         (i_out_ready),
        .o_out_valid         (o_out_valid),
        .o_kind              (o_kind),
        .o_packet_number     (o_packet_number),
        .o_current_transfer  (o_current_transfer),
        .o_advertised_count  (o_advertised_count),
        .i_cmd               (cmd),
        .o_status            (status)
    );

endmodule

>>> sv/swarq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swarq_checker
// Port-level checks of the ARQ sender, bound to the top level.
// ----------------------------------------------------------------------------
`include "sliding_window_arq_sender_assert.svh"

module swarq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [2:0]  i_command,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_packet_number,
    input logic [15:0] o_current_transfer,
    input logic [8:0]  o_advertised_count
);
    import swarq_pkg::*;

    `SWARQ_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_kind) && $stable(o_packet_number) && $stable(o_current_transfer) && $stable(o_advertised_count), "result changed while stalled")
    `SWARQ_ASSERT_NOW(a_done_num, o_out_valid && o_kind == KIND_DONE, o_packet_number == 8'd0, "complete with nonzero number")
    `SWARQ_ASSERT_NOW(a_marker_fields, o_out_valid && o_kind == KIND_MARKER, o_packet_number == 8'd0 && o_advertised_count == 9'd0, "marker fields not zero")
    `SWARQ_ASSERT_NEXT(a_tick_busy, i_in_valid && o_in_ready && i_command == CMD_TICK, !o_in_ready, "request taken during tick")

endmodule

bind sliding_window_arq_sender swarq_checker u_swarq_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .i_command          (i_command),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_kind             (o_kind),
    .o_packet_number    (o_packet_number),
    .o_current_transfer (o_current_transfer),
    .o_advertised_count (o_advertised_count)
);

>>> dv/sliding_window_arq_sender_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_arq_sender_tb
// Drives start, ack, tick, transmit-done and abort requests into the ARQ
// sender and compares each packet it emits with a local model of the sender
// state. Traffic is mostly realistic transfers, with some noise and broken
// sequences. Register settings change between phases, extremes included.
// ----------------------------------------------------------------------------
module sliding_window_arq_sender_tb;
    import swarq_pkg::*;

    localparam int NPKT   = DEF_MAX_PACKETS;
    localparam int WIN    = DEF_WINDOW_SIZE;
    localparam int GSIZE  = DEF_GROUP_SIZE;
    localparam int NGRP   = NPKT / GSIZE;
    localparam int SETTLE = 200;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] now_ms;
        logic [8:0]  requested;
        logic [15:0] ack_xfer;
        logic [2:0]  ack_word;
        logic [31:0] ack_bits;
        logic [8:0]  ack_limit;
    } t_request;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  number;
        logic [15:0] xfer;
        logic [8:0]  count;
    } t_packet;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_command = '0;
    logic [31:0] i_now_ms = '0;
    logic [8:0]  i_requested_packets = '0;
    logic [15:0] i_ack_transfer = '0;
    logic [2:0]  i_ack_word_index = '0;
    logic [31:0] i_ack_bits = '0;
    logic [8:0]  i_ack_limit = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_packet_number;
    logic [15:0] o_current_transfer;
    logic [8:0]  o_advertised_count;

    sliding_window_arq_sender uut (.*);

    always #2 i_clk = ~i_clk;

    // sender model state
    logic [15:0] m_retx_timeout, m_min_gap, m_start_guard;
    bit          m_acked [NPKT];
    bit          m_sent [NPKT];
    logic [31:0] m_sent_at [NPKT];
    bit          m_group_pend [NGRP];
    int unsigned m_base, m_total;
    logic [15:0] m_xfer;
    bit          m_busy, m_active, m_complete;
    logic [31:0] m_last_end, m_ready_at;
    int unsigned m_markers;

    t_request pending_requests [$];
    t_packet  expected_packets [$];
    int       error_count = 0;
    bit       in_taken = 1'b0;
    bit       no_idle = 1'b0;
    int       in_gap = 0, out_gap = 0;

    // generator side bookkeeping
    logic [31:0] gen_now = 32'd1000;
    logic [15:0] gen_xfer = 16'd0;
    int          gen_count = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic bit gap_clear(input logic [31:0] now);
        return !m_busy && (now - m_last_end) >= {16'd0, m_min_gap};
    endfunction

    task automatic predict_packet(input t_request r, output bit emitted, output t_packet p);
        int unsigned req, wend, i, g;
        bit all;
        emitted = 0;
        p = '0;
        case (r.command)
            CMD_START: begin
                req = r.requested > NPKT ? NPKT : r.requested;
                m_active = 0;
                m_complete = 0;
                m_xfer = m_xfer + 16'd1;
                if (m_xfer == 16'd0) m_xfer = 16'd1;
                if (req == 0) begin
                    m_total = 0;
                    m_markers = MARKER_REPEATS;
                    m_complete = 1;
                end else begin
                    m_total = req;
                    for (i = 0; i < NPKT; i++) begin
                        m_acked[i] = 0;
                        m_sent[i] = 0;
                    end
                    for (i = 0; i < NGRP; i++) m_group_pend[i] = 0;
                    m_base = 0;
                    m_active = 1;
                    m_ready_at = r.now_ms + {16'd0, m_start_guard};
                end
            end
            CMD_ACK: begin
                if (r.ack_xfer == m_xfer) begin
                    for (i = 0; i < 32; i++)
                        if (r.ack_bits[i] && r.ack_word * 32 + i < r.ack_limit)
                            m_acked[r.ack_word * 32 + i] = 1;
                    while (m_base < m_total && m_acked[m_base]) m_base++;
                    all = 1;
                    for (i = 0; i < m_total; i++)
                        if (!m_acked[i]) all = 0;
                    if (all && !m_complete) begin
                        emitted = 1;
                        p = '{KIND_DONE, 8'd0, m_xfer, m_total[8:0]};
                    end
                    if (all) m_complete = 1;
                end
            end
            CMD_TXDONE: begin
                m_busy = 0;
                m_last_end = r.now_ms;
            end
            CMD_ABORT: m_active = 0;
            CMD_TICK: begin
                if (m_markers > 0 && gap_clear(r.now_ms)) begin
                    emitted = 1;
                    p = '{KIND_MARKER, 8'd0, m_xfer, 9'd0};
                    m_busy = 1;
                    m_markers--;
                end
                if (m_active && !m_complete && !((r.now_ms - m_ready_at) >> 31)) begin
                    wend = m_base + WIN;
                    if (wend > m_total) wend = m_total;
                    for (i = m_base; i < wend; i++) begin
                        if (!m_acked[i] && !m_sent[i]) begin
                            if (gap_clear(r.now_ms)) begin
                                emitted = 1;
                                p = '{KIND_DATA, i[7:0], m_xfer, m_total[8:0]};
                                m_busy = 1;
                                m_sent[i] = 1;
                                m_sent_at[i] = r.now_ms;
                                if (i % GSIZE == GSIZE - 1 || i + 1 == m_total)
                                    m_group_pend[i / GSIZE] = 1;
                            end
                            break;
                        end
                    end
                    if (!m_busy) begin
                        for (g = 0; g < NGRP; g++) begin
                            if (m_group_pend[g]) begin
                                if (gap_clear(r.now_ms)) begin
                                    emitted = 1;
                                    p = '{KIND_PARITY, g[7:0], m_xfer, m_total[8:0]};
                                    m_busy = 1;
                                    m_group_pend[g] = 0;
                                end
                                break;
                            end
                        end
                    end
                    // expire stale packets and drop their parity notice
                    for (i = m_base; i < wend; i++) begin
                        if (m_sent[i] && !m_acked[i] &&
                            (r.now_ms - m_sent_at[i]) > {16'd0, m_retx_timeout}) begin
                            m_sent[i] = 0;
                            m_group_pend[i / GSIZE] = 0;
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // monitor: register writes, accepted requests and emitted packets
    always @(posedge i_clk) begin
        t_packet p, want;
        bit emitted;
        in_taken <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RETX_TIMEOUT: m_retx_timeout = i_cfg_data;
                    CFG_MIN_GAP:      m_min_gap = i_cfg_data;
                    CFG_START_GUARD:  m_start_guard = i_cfg_data;
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_packets.size() == 0) begin
                    report_mismatch("unexpected packet kind", o_kind, -1);
                end else begin
                    want = expected_packets.pop_front();
                    if (o_kind != want.kind) report_mismatch("kind", o_kind, want.kind);
                    if (o_packet_number != want.number)
                        report_mismatch("packet_number", o_packet_number, want.number);
                    if (o_current_transfer != want.xfer)
                        report_mismatch("current_transfer", o_current_transfer, want.xfer);
                    if (o_advertised_count != want.count)
                        report_mismatch("advertised_count", o_advertised_count, want.count);
                end
            end
            if (i_in_valid && o_in_ready) begin
                predict_packet(t_request'({i_command, i_now_ms, i_requested_packets,
                    i_ack_transfer, i_ack_word_index, i_ack_bits, i_ack_limit}), emitted, p);
                if (emitted) expected_packets.push_back(p);
            end
        end
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // request driver
    always @(negedge i_clk) begin
        t_request r;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                r = pending_requests.pop_front();
                {i_command, i_now_ms, i_requested_packets, i_ack_transfer,
                    i_ack_word_index, i_ack_bits, i_ack_limit} <= r;
                i_in_valid <= 1'b1;
                in_gap <= draw_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result side stalls
    always @(negedge i_clk) begin
        if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) out_gap <= draw_gap();
        end
    end

    task automatic queue_request(input t_command cmd, input logic [8:0] req = 0,
                                 input logic [15:0] xfer = 0, input logic [2:0] word = 0,
                                 input logic [31:0] bits = 0, input logic [8:0] lim = 0);
        pending_requests.push_back('{cmd, gen_now, req, xfer, word, bits, lim});
        gen_count++;
        if (cmd == CMD_START) begin
            gen_xfer = gen_xfer + 16'd1;
            if (gen_xfer == 16'd0) gen_xfer = 16'd1;
        end
    endtask

    task automatic advance_clock_ms();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) gen_now = gen_now + $urandom_range(0, 40);
        else if (r < 98) gen_now = gen_now + $urandom_range(0, 5000);
        else gen_now = $urandom;
    endtask

    // one transfer: start, then ticks, completions and acks with random content
    task automatic queue_transfer(input int n);
        int steps, r, words;
        logic [31:0] bits;
        queue_request(CMD_START, n[8:0]);
        words = n > NPKT ? NPKT / 32 : (n + 31) / 32;
        if (words == 0) words = 1;
        steps = 20 + (n > 40 ? 80 : 3 * n);
        repeat (steps) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                advance_clock_ms();
                queue_request(CMD_TICK);
            end else if (r < 70) begin
                queue_request(CMD_TXDONE);
            end else if (r < 88) begin
                bits = $urandom_range(0, 2) == 0 ? $urandom : ($urandom | $urandom);
                queue_request(CMD_ACK, 0, gen_xfer, $urandom_range(0, words - 1), bits,
                    $urandom_range(0, 5) == 0 ? 9'($urandom) : n[8:0]);
            end else if (r < 94) begin
                queue_request(CMD_ACK, 0, 16'($urandom), 3'($urandom), $urandom, 9'($urandom));
            end else if (r < 97) begin
                pending_requests.push_back('{3'($urandom_range(5, 7)), $urandom,
                    9'($urandom), 16'($urandom), 3'($urandom), $urandom, 9'($urandom)});
            end else if (r < 98) begin
                queue_request(CMD_ABORT);
            end else begin
                queue_request(CMD_START, 9'($urandom_range(0, 3)));
            end
        end
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_requests.size() > 0 || i_in_valid || expected_packets.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int phase, n;
        m_retx_timeout = RST_RETX_TIMEOUT;
        m_min_gap = RST_MIN_GAP;
        m_start_guard = RST_START_GUARD;
        for (int i = 0; i < NPKT; i++) begin
            m_acked[i] = 0;
            m_sent[i] = 0;
            m_sent_at[i] = '0;
        end
        for (int i = 0; i < NGRP; i++) m_group_pend[i] = 0;
        m_base = 0; m_total = 0; m_xfer = '0;
        m_busy = 0; m_active = 0; m_complete = 0;
        m_last_end = '0; m_ready_at = '0; m_markers = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset defaults first
        queue_request(CMD_ACK, 0, 16'd0, 3'd0, 32'd0, 9'd0);
        pending_requests.push_back('{3'd5, '1, '1, '1, '1, '1, '1});
        pending_requests.push_back('{3'd7, '0, '0, '0, '0, '0, '0});
        queue_request(CMD_TXDONE);
        queue_request(CMD_START, 9'd0);
        repeat (3) begin
            gen_now = gen_now + 30;
            queue_request(CMD_TICK);
            queue_request(CMD_TXDONE);
        end
        queue_request(CMD_START, 9'd511);
        queue_request(CMD_ABORT);
        queue_request(CMD_START, 9'd256);
        for (int w = 0; w < 8; w++)
            queue_request(CMD_ACK, 0, gen_xfer, w[2:0], 32'hFFFF_FFFF, 9'd256);
        queue_request(CMD_START, 9'd5);
        gen_now = gen_now + 200;
        queue_request(CMD_TICK);
        queue_request(CMD_ACK, 0, gen_xfer, 3'd0, 32'h1F, 9'd5);
        drain();

        for (phase = 0; gen_count < 950; phase++) begin
            case (phase % 4)
                0: begin
                    write_register(CFG_RETX_TIMEOUT, 16'd0);
                    write_register(CFG_MIN_GAP, 16'd0);
                    write_register(CFG_START_GUARD, 16'd0);
                end
                1: begin
                    write_register(CFG_RETX_TIMEOUT, 16'hFFFF);
                    write_register(CFG_MIN_GAP, 16'hFFFF);
                    write_register(CFG_START_GUARD, 16'hFFFF);
                end
                2: begin
                    write_register(CFG_RETX_TIMEOUT, RST_RETX_TIMEOUT);
                    write_register(CFG_MIN_GAP, RST_MIN_GAP);
                    write_register(CFG_START_GUARD, RST_START_GUARD);
                end
                default: begin
                    write_register(CFG_RETX_TIMEOUT, 16'($urandom_range(0, 300)));
                    write_register(CFG_MIN_GAP, 16'($urandom_range(0, 30)));
                    write_register(CFG_START_GUARD, 16'($urandom));
                end
            endcase
            no_idle = (phase % 3 == 2);
            repeat (3) begin
                n = $urandom_range(0, 99);
                if (n < 10) n = 0;
                else if (n < 85) n = $urandom_range(1, 24);
                else if (n < 95) n = $urandom_range(25, 256);
                else n = $urandom_range(257, 511);
                queue_transfer(n);
            end
            drain();
        end

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule

>>> sliding_window_arq_sender.f
+incdir+sv
sv/swarq_pkg.sv
sv/swarq_ctrl.sv
sv/swarq_dp.sv
sv/sliding_window_arq_sender.sv
sv/swarq_checker.sv
dv/sliding_window_arq_sender_tb.sv
